// ----- src/yay0lz_pkg.sv -----
// Shared constants, codes and types of the Yay0 LZ decompressor.
package yay0lz_pkg;

    // History window; the depth must be a power of two.
    localparam int WINDOW_DEPTH = 4096;
    localparam int WIN_AW       = $clog2(WINDOW_DEPTH);

    // Bytes packed into one result beat.
    localparam int LANE_BYTES = 8;
    localparam int LANE_IW    = (LANE_BYTES > 1) ? $clog2(LANE_BYTES) : 1;

    // Fixed field widths.
    localparam int DATA_W     = 64;
    localparam int CNT_W      = 4;
    localparam int SIZE_W     = 24;
    localparam int FLAG_W     = 32;
    localparam int LEFT_W     = 6;
    localparam int LEN_W      = 9;
    localparam int S_TDATA_W  = 64;
    localparam int M_TDATA_W  = 72;

    localparam logic [SIZE_W-1:0] PRODUCED_MAX = {SIZE_W{1'b1}};

    // Item kinds carried in s_tuser.
    localparam logic OP_MASK  = 1'b0;
    localparam logic OP_TOKEN = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_COPY
    } seq_state_t;

    typedef struct packed {
        logic              operation;
        logic [FLAG_W-1:0] mask_word;
        logic [7:0]        literal_byte;
        logic [15:0]       link_code;
        logic [7:0]        count_byte;
    } in_item_t;

    // One byte handed from the sequencer to the write-back and packing stage.
    typedef struct packed {
        logic               valid;
        logic               use_lit;
        logic [7:0]         lit;
        logic [WIN_AW-1:0]  raddr;
        logic [WIN_AW-1:0]  waddr;
        logic               rd_ok;
        logic [LANE_IW-1:0] lane;
        logic               complete;
        logic               last;
    } issue_t;

endpackage

// ----- src/yay0_lz_decompressor.sv -----
// Yay0 LZ decompressor top level: stream ports, size register and assertions.
//
// Each input beat is either a 32-bit mask word (s_tuser low) or one token
// (s_tuser high). A literal's beat has to move into the result register
// before the next item is taken. A back-reference copy of N bytes (3 to 273)
// has a setup step, then moves one byte per cycle through the 4 KiB history
// RAM, which is read and written once per cycle, while the result channel
// takes each beat; the last beat then moves into the result register. A copy
// whose last beat holds a single byte after a full one waits for the result
// register. Bytes leave packed up to eight per result beat, and a stalled
// result channel holds the copy back. The history needs no clearing pass
// after reset: entries not yet written since reset read as zero by tracking
// the write pointer. The user must write the size register on the cfg
// channel only while the block is idle; the block itself does not enforce it.
module yay0_lz_decompressor (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // Fields from bit 0: mask_word, literal_byte, link_code, count_byte.
    input  logic [yay0lz_pkg::S_TDATA_W-1:0]    s_tdata,
    // Fields from bit 0: operation.
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // Fields from bit 0: data_bytes, byte_count, then zero padding.
    output logic [yay0lz_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                                m_tlast,
    // Fields from bit 0: finished, missing_mask.
    output logic [1:0]                          m_tuser,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [yay0lz_pkg::SIZE_W-1:0]       cfg_data
);

    logic [yay0lz_pkg::SIZE_W-1:0] size_reg;

    yay0lz_pkg::in_item_t item;
    yay0lz_pkg::issue_t   issue;

    logic                            miss_req;
    logic                            busy;
    logic                            out_free_next;
    logic                            ram_we;
    logic [yay0lz_pkg::WIN_AW-1:0]   ram_waddr;
    logic [7:0]                      ram_wdata;
    logic [7:0]                      ram_rdata;
    logic [yay0lz_pkg::DATA_W-1:0]   out_data;
    logic [yay0lz_pkg::CNT_W-1:0]    out_count;
    logic                            out_finished;
    logic                            out_missing;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            size_reg <= cfg_data;
        end
    end

    always_comb begin
        item.operation    = s_tuser;
        item.mask_word    = s_tdata[31:0];
        item.literal_byte = s_tdata[39:32];
        item.link_code    = s_tdata[55:40];
        item.count_byte   = s_tdata[63:56];
    end

    yay0lz_seq u_seq (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .item          (item),
        .out_free_next (out_free_next),
        .issue         (issue),
        .miss_req      (miss_req),
        .busy          (busy)
    );

    yay0lz_hist_ram #(
        .ADDR_W (yay0lz_pkg::WIN_AW),
        .DATA_W (8)
    ) u_hist (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (issue.valid && !issue.use_lit),
        .raddr (issue.raddr),
        .rdata (ram_rdata)
    );

    yay0lz_pack u_pack (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .issue         (issue),
        .miss_req      (miss_req),
        .ram_rdata     (ram_rdata),
        .decoded_size  (size_reg),
        .ram_we        (ram_we),
        .ram_waddr     (ram_waddr),
        .ram_wdata     (ram_wdata),
        .out_free_next (out_free_next),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .out_data      (out_data),
        .out_count     (out_count),
        .out_last      (m_tlast),
        .out_finished  (out_finished),
        .out_missing   (out_missing)
    );

    assign m_tdata = {{(yay0lz_pkg::M_TDATA_W - yay0lz_pkg::DATA_W - yay0lz_pkg::CNT_W){1'b0}},
                      out_count, out_data};
    assign m_tuser = {out_missing, out_finished};

    // A missing-mask result carries no bytes and closes its token.
    a_miss_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_missing) |-> (out_count == '0) && m_tlast)
        else $error("missing-mask result with bytes or without last");

    // Only a missing-mask result may be empty, and no beat holds more than eight bytes.
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !out_missing) |->
            (out_count != '0) &&
            (out_count <= yay0lz_pkg::CNT_W'(yay0lz_pkg::LANE_BYTES)))
        else $error("result byte count out of range");

    // No new item is taken while a copy is still being sequenced.
    a_busy_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        busy |-> !s_tready)
        else $error("input accepted during a copy");

    // A byte that closes a beat must find the output register free.
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (issue.valid && issue.complete) |=> !(m_tvalid && !$past(m_tready) && $past(m_tvalid)))
        else $error("result register overrun");

endmodule

// ----- src/yay0lz_hist_ram.sv -----
// Generic simple dual-port RAM with registered read data.
module yay0lz_hist_ram #(
    parameter int ADDR_W = 12,
    parameter int DATA_W = 8
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- src/yay0lz_seq.sv -----
// Token decoder and copy sequencer: flag bits, write pointer and history reads.
module yay0lz_seq (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  yay0lz_pkg::in_item_t item,
    input  logic                out_free_next,
    output yay0lz_pkg::issue_t  issue,
    output logic                miss_req,
    output logic                busy
);

    localparam int CALC_W = (yay0lz_pkg::WIN_AW > 13) ? yay0lz_pkg::WIN_AW : 13;
    localparam logic [yay0lz_pkg::LANE_IW-1:0] LANE_LAST =
        yay0lz_pkg::LANE_IW'(yay0lz_pkg::LANE_BYTES - 1);
    localparam logic [yay0lz_pkg::WIN_AW-1:0] WIN_LAST =
        yay0lz_pkg::WIN_AW'(yay0lz_pkg::WINDOW_DEPTH - 1);

    yay0lz_pkg::seq_state_t state_reg, state_next;

    logic [yay0lz_pkg::FLAG_W-1:0]  flag_reg, flag_next;
    logic [yay0lz_pkg::LEFT_W-1:0]  left_reg, left_next;
    logic [yay0lz_pkg::WIN_AW-1:0]  wp_reg, wp_next;
    logic                           wrapped_reg, wrapped_next;
    logic [yay0lz_pkg::WIN_AW-1:0]  rd_reg, rd_next;
    logic [yay0lz_pkg::LEN_W-1:0]   rem_reg, rem_next;
    logic [yay0lz_pkg::LANE_IW-1:0] lane_reg, lane_next;

    logic                          accept;
    logic                          is_token;
    logic                          no_flags;
    logic                          flag_top;
    logic [CALC_W-1:0]             link_dist;
    logic [3:0]                    nibble;
    logic [yay0lz_pkg::LEN_W-1:0]  copy_len;
    logic [yay0lz_pkg::WIN_AW-1:0] copy_rd;
    logic                          cp_complete;
    logic                          cp_go;

    always_comb begin
        accept    = s_tvalid && s_tready;
        is_token  = (item.operation == yay0lz_pkg::OP_TOKEN);
        no_flags  = (left_reg == '0);
        flag_top  = flag_reg[yay0lz_pkg::FLAG_W-1];
        link_dist = CALC_W'(item.link_code[11:0]) + CALC_W'(1);
        nibble    = item.link_code[15:12];
        if (nibble == 4'd0) begin
            copy_len = yay0lz_pkg::LEN_W'(item.count_byte) + yay0lz_pkg::LEN_W'(18);
        end else begin
            copy_len = yay0lz_pkg::LEN_W'(nibble) + yay0lz_pkg::LEN_W'(2);
        end
        // The window is a power of two, so the modulo is a plain truncation.
        copy_rd     = yay0lz_pkg::WIN_AW'(CALC_W'(wp_reg) - link_dist);
        cp_complete = (lane_reg == LANE_LAST) || (rem_reg == yay0lz_pkg::LEN_W'(1));
        // A byte that closes a beat may only go out if the output register frees up.
        cp_go       = (state_reg == yay0lz_pkg::ST_COPY) && (!cp_complete || out_free_next);
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            yay0lz_pkg::ST_IDLE: begin
                if (accept && is_token && !no_flags && !flag_top) begin
                    state_next = yay0lz_pkg::ST_COPY;
                end
            end
            yay0lz_pkg::ST_COPY: begin
                if (cp_go && (rem_reg == yay0lz_pkg::LEN_W'(1))) begin
                    state_next = yay0lz_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = yay0lz_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        flag_next    = flag_reg;
        left_next    = left_reg;
        wp_next      = wp_reg;
        wrapped_next = wrapped_reg;
        rd_next      = rd_reg;
        rem_next     = rem_reg;
        lane_next    = lane_reg;
        issue        = '0;
        miss_req     = 1'b0;
        s_tready     = 1'b0;
        busy         = 1'b0;
        case (state_reg)
            yay0lz_pkg::ST_IDLE: begin
                s_tready = out_free_next;
                if (accept) begin
                    if (!is_token) begin
                        flag_next = item.mask_word;
                        left_next = yay0lz_pkg::LEFT_W'(yay0lz_pkg::FLAG_W);
                    end else if (no_flags) begin
                        miss_req = 1'b1;
                    end else begin
                        flag_next = flag_reg << 1;
                        left_next = left_reg - yay0lz_pkg::LEFT_W'(1);
                        if (flag_top) begin
                            issue.valid    = 1'b1;
                            issue.use_lit  = 1'b1;
                            issue.lit      = item.literal_byte;
                            issue.waddr    = wp_reg;
                            issue.complete = 1'b1;
                            issue.last     = 1'b1;
                            wp_next        = wp_reg + yay0lz_pkg::WIN_AW'(1);
                            wrapped_next   = wrapped_reg || (wp_reg == WIN_LAST);
                        end else begin
                            rd_next   = copy_rd;
                            rem_next  = copy_len;
                            lane_next = '0;
                        end
                    end
                end
            end
            yay0lz_pkg::ST_COPY: begin
                busy = 1'b1;
                if (cp_go) begin
                    issue.valid    = 1'b1;
                    issue.raddr    = rd_reg;
                    issue.waddr    = wp_reg;
                    // Entries not yet written since reset read as zero.
                    issue.rd_ok    = wrapped_reg || (rd_reg < wp_reg);
                    issue.lane     = lane_reg;
                    issue.complete = cp_complete;
                    issue.last     = (rem_reg == yay0lz_pkg::LEN_W'(1));
                    wp_next        = wp_reg + yay0lz_pkg::WIN_AW'(1);
                    wrapped_next   = wrapped_reg || (wp_reg == WIN_LAST);
                    rd_next        = rd_reg + yay0lz_pkg::WIN_AW'(1);
                    rem_next       = rem_reg - yay0lz_pkg::LEN_W'(1);
                    lane_next      = cp_complete ? '0 : lane_reg + yay0lz_pkg::LANE_IW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= yay0lz_pkg::ST_IDLE;
            flag_reg    <= '0;
            left_reg    <= '0;
            wp_reg      <= '0;
            wrapped_reg <= 1'b0;
            rd_reg      <= '0;
            rem_reg     <= '0;
            lane_reg    <= '0;
        end else begin
            state_reg   <= state_next;
            flag_reg    <= flag_next;
            left_reg    <= left_next;
            wp_reg      <= wp_next;
            wrapped_reg <= wrapped_next;
            rd_reg      <= rd_next;
            rem_reg     <= rem_next;
            lane_reg    <= lane_next;
        end
    end

endmodule

// ----- src/yay0lz_pack.sv -----
// Write-back stage: forwards read data, writes the history, packs bytes into result beats.
module yay0lz_pack (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  yay0lz_pkg::issue_t                  issue,
    input  logic                                miss_req,
    input  logic [7:0]                          ram_rdata,
    input  logic [yay0lz_pkg::SIZE_W-1:0]       decoded_size,
    output logic                                ram_we,
    output logic [yay0lz_pkg::WIN_AW-1:0]       ram_waddr,
    output logic [7:0]                          ram_wdata,
    output logic                                out_free_next,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [yay0lz_pkg::DATA_W-1:0]       out_data,
    output logic [yay0lz_pkg::CNT_W-1:0]        out_count,
    output logic                                out_last,
    output logic                                out_finished,
    output logic                                out_missing
);

    localparam logic [yay0lz_pkg::SIZE_W-1:0] PRODUCED_MAX_L = yay0lz_pkg::PRODUCED_MAX;

    yay0lz_pkg::issue_t b_reg;
    logic               fwd_hit_reg, fwd_hit_next;
    logic [7:0]         fwd_data_reg;

    logic [yay0lz_pkg::LANE_BYTES-1:0][7:0] acc_reg, acc_next, lanes_cur;
    logic [yay0lz_pkg::SIZE_W-1:0]          produced_reg, produced_next;

    logic                              m_valid_reg, m_valid_next;
    logic [yay0lz_pkg::DATA_W-1:0]     m_data_reg, m_data_next;
    logic [yay0lz_pkg::CNT_W-1:0]      m_count_reg, m_count_next;
    logic                              m_last_reg, m_last_next;
    logic                              m_fin_reg, m_fin_next;
    logic                              m_miss_reg, m_miss_next;

    logic [7:0] cur_byte;
    logic       beat_load;

    always_comb begin
        if (b_reg.use_lit) begin
            cur_byte = b_reg.lit;
        end else if (fwd_hit_reg) begin
            cur_byte = fwd_data_reg;
        end else if (b_reg.rd_ok) begin
            cur_byte = ram_rdata;
        end else begin
            cur_byte = 8'd0;
        end

        ram_we    = b_reg.valid;
        ram_waddr = b_reg.waddr;
        ram_wdata = cur_byte;

        // The RAM returns old data when read and written at once, so take the new byte.
        fwd_hit_next = b_reg.valid && issue.valid && !issue.use_lit &&
                       (issue.raddr == b_reg.waddr);

        out_free_next = (!m_valid_reg || m_tready) && !(b_reg.valid && b_reg.complete);

        if (b_reg.valid && (produced_reg != PRODUCED_MAX_L)) begin
            produced_next = produced_reg + yay0lz_pkg::SIZE_W'(1);
        end else begin
            produced_next = produced_reg;
        end

        lanes_cur = acc_reg;
        if (b_reg.valid) begin
            lanes_cur[b_reg.lane] = cur_byte;
        end
        beat_load = b_reg.valid && b_reg.complete;
        acc_next  = beat_load ? '0 : lanes_cur;

        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_count_next = m_count_reg;
        m_last_next  = m_last_reg;
        m_fin_next   = m_fin_reg;
        m_miss_next  = m_miss_reg;
        if (beat_load) begin
            m_valid_next = 1'b1;
            m_data_next  = yay0lz_pkg::DATA_W'(lanes_cur);
            m_count_next = yay0lz_pkg::CNT_W'(b_reg.lane) + yay0lz_pkg::CNT_W'(1);
            m_last_next  = b_reg.last;
            m_fin_next   = (produced_next >= decoded_size);
            m_miss_next  = 1'b0;
        end else if (miss_req) begin
            m_valid_next = 1'b1;
            m_data_next  = '0;
            m_count_next = '0;
            m_last_next  = 1'b1;
            m_fin_next   = (produced_reg >= decoded_size);
            m_miss_next  = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_reg        <= '0;
            fwd_hit_reg  <= 1'b0;
            acc_reg      <= '0;
            produced_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            b_reg        <= issue;
            fwd_hit_reg  <= fwd_hit_next;
            acc_reg      <= acc_next;
            produced_reg <= produced_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        fwd_data_reg <= cur_byte;
        m_data_reg   <= m_data_next;
        m_count_reg  <= m_count_next;
        m_last_reg   <= m_last_next;
        m_fin_reg    <= m_fin_next;
        m_miss_reg   <= m_miss_next;
    end

    assign m_tvalid     = m_valid_reg;
    assign out_data     = m_data_reg;
    assign out_count    = m_count_reg;
    assign out_last     = m_last_reg;
    assign out_finished = m_fin_reg;
    assign out_missing  = m_miss_reg;

endmodule

// ----- dv/tb.sv -----
// Self-checking testbench for the Yay0 LZ decompressor: directed table, then random token runs.
`timescale 1ns / 100ps

module tb;
    import yay0lz_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    // Settle time after the last result beat; a mask load gives no beat of its own.
    localparam int SETTLE_CYCLES = 16;

    typedef struct packed {
        logic [DATA_W-1:0] bytes;
        logic [CNT_W-1:0]  count;
        logic              last;
        logic              done;
        logic              missing;
    } out_beat_t;

    typedef struct {
        in_item_t  item;
        bit        typed;
        out_beat_t want;
    } stim_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 s_tuser = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;
    logic [1:0]           m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [SIZE_W-1:0]    cfg_data = '0;

    // Mirror of the decoder state.
    logic [7:0]        hist [WINDOW_DEPTH];
    logic [WIN_AW-1:0] wr_pos = '0;
    logic [FLAG_W-1:0] flag_word = '0;
    logic [LEFT_W-1:0] flags_left = '0;
    logic [SIZE_W-1:0] produced = '0;
    logic [SIZE_W-1:0] size_reg = '0;

    out_beat_t due_beats[$];
    int        mismatch_count = 0;
    int        cycle_count = 0;
    int        gap_odds = 0;
    int        stall_odds = 0;
    int        stall_left = 0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    yay0_lz_decompressor i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        foreach (hist[i]) hist[i] = 8'h00;
    end

    function automatic out_beat_t beat_now(logic [DATA_W-1:0] bytes, int count, bit last,
                                           bit missing);
        out_beat_t b;
        b.bytes   = bytes;
        b.count   = CNT_W'(count);
        b.last    = last;
        b.done    = (produced >= size_reg);
        b.missing = missing;
        return b;
    endfunction

    function automatic void push_byte(logic [7:0] b);
        hist[wr_pos] = b;
        wr_pos++;
        if (produced != PRODUCED_MAX) produced++;
    endfunction

    // Advances the mirror by one accepted item and returns the beats it should cause.
    function automatic void decode_item(input in_item_t it, ref out_beat_t beats[$]);
        logic [WIN_AW-1:0] rd_pos;
        logic [DATA_W-1:0] acc;
        logic [7:0]        b;
        bit                is_lit;
        int                len;
        int                lane;
        beats.delete();
        if (it.operation == OP_MASK) begin
            flag_word  = it.mask_word;
            flags_left = LEFT_W'(FLAG_W);
            return;
        end
        if (flags_left == 0) begin
            beats.push_back(beat_now('0, 0, 1'b1, 1'b1));
            return;
        end
        is_lit     = flag_word[FLAG_W-1];
        flag_word  = flag_word << 1;
        flags_left = flags_left - 1'b1;
        if (is_lit) begin
            push_byte(it.literal_byte);
            beats.push_back(beat_now(DATA_W'(it.literal_byte), 1, 1'b1, 1'b0));
            return;
        end
        rd_pos = WIN_AW'(wr_pos - it.link_code[11:0] - 1);
        len = (it.link_code[15:12] == 4'h0) ? int'(it.count_byte) + 18
                                            : int'(it.link_code[15:12]) + 2;
        acc  = '0;
        lane = 0;
        for (int i = 0; i < len; i++) begin
            // Byte by byte, so a copy that overlaps its own output repeats bytes.
            b = hist[rd_pos];
            rd_pos++;
            push_byte(b);
            acc[8*lane +: 8] = b;
            lane++;
            if (lane == LANE_BYTES || i == len - 1) begin
                beats.push_back(beat_now(acc, lane, i == len - 1, 1'b0));
                acc  = '0;
                lane = 0;
            end
        end
    endfunction

    task automatic log_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [DATA_W-1:0] got,
                               input logic [DATA_W-1:0] want);
        if (got !== want)
            log_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
    endtask

    // Result checker: every accepted beat is matched against the oldest expectation.
    always @(posedge aclk) begin
        out_beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (due_beats.size() == 0) begin
                log_mismatch($sformatf("beat with no expectation, tdata 0x%0h", m_tdata));
            end else begin
                want = due_beats.pop_front();
                check_field("data_bytes", m_tdata[DATA_W-1:0], want.bytes);
                check_field("byte_count", DATA_W'(m_tdata[DATA_W +: CNT_W]), DATA_W'(want.count));
                check_field("last", DATA_W'(m_tlast), DATA_W'(want.last));
                check_field("finished", DATA_W'(m_tuser[0]), DATA_W'(want.done));
                check_field("missing_mask", DATA_W'(m_tuser[1]), DATA_W'(want.missing));
            end
        end
    end

    // Result side back-pressure in random bursts.
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 5);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_item(input in_item_t it, input bit typed, input out_beat_t want);
        out_beat_t got[$];
        if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.operation;
        s_tdata  <= {it.count_byte, it.link_code, it.literal_byte, it.mask_word};
        do @(posedge aclk); while (!s_tready);
        decode_item(it, got);
        if (typed)
            due_beats.push_back(want);
        else
            foreach (got[i]) due_beats.push_back(got[i]);
    endtask

    // Holds the input side until every expected beat is out and the block has settled.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (due_beats.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_size(input logic [SIZE_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        size_reg = value;
    endtask

    function automatic in_item_t random_token();
        in_item_t it;
        it.operation    = OP_TOKEN;
        it.mask_word    = $urandom;
        it.literal_byte = 8'($urandom);
        it.count_byte   = 8'($urandom);
        // Mostly short copies from nearby; long extended copies now and then.
        it.link_code[15:12] = ($urandom_range(0, 7) == 0) ? 4'h0 : 4'($urandom_range(1, 15));
        it.link_code[11:0]  = ($urandom_range(0, 3) == 0) ? 12'($urandom)
                                                          : 12'($urandom_range(0, 15));
        return it;
    endfunction

    // Well-formed groups: a mask word and up to 32 tokens, sometimes overrunning the flags.
    task automatic run_phase(input int n_items);
        in_item_t it;
        int       n_tok;
        while (n_items > 0) begin
            it = random_token();
            it.operation = OP_MASK;
            send_item(it, 1'b0, '0);
            n_items--;
            n_tok = $urandom_range(1, 32);
            if (n_tok > n_items) n_tok = n_items;
            if ($urandom_range(0, 5) == 0) n_tok = 32 + $urandom_range(1, 2);
            repeat (n_tok) begin
                send_item(random_token(), 1'b0, '0);
                n_items--;
            end
        end
    endtask

    stim_row_t directed_rows [21] = '{
        // A token straight after reset finds no flags loaded.
        '{'{OP_TOKEN, 32'h0, 8'h5C, 16'h1234, 8'h00}, 1'b1, '{64'h0, 4'd0, 1'b1, 1'b0, 1'b1}},
        '{'{OP_MASK,  32'hFFFF_FFFF, 8'h00, 16'h0000, 8'h00}, 1'b0, '0},
        '{'{OP_TOKEN, 32'h0, 8'hFF, 16'hFFFF, 8'hFF}, 1'b1, '{64'hFF, 4'd1, 1'b1, 1'b0, 1'b0}},
        '{'{OP_TOKEN, 32'h0, 8'h00, 16'h0000, 8'h00}, 1'b1, '{64'h00, 4'd1, 1'b1, 1'b0, 1'b0}},
        '{'{OP_TOKEN, 32'h0, 8'hA5, 16'h0000, 8'h00}, 1'b1, '{64'hA5, 4'd1, 1'b1, 1'b0, 1'b0}},
        // Reload with all copies while flags are still left.
        '{'{OP_MASK,  32'h0000_0000, 8'hFF, 16'hFFFF, 8'hFF}, 1'b0, '0},
        '{'{OP_TOKEN, 32'h0, 8'h00, 16'h1000, 8'h00}, 1'b0, '0},
        '{'{OP_TOKEN, 32'h0, 8'h00, 16'h2002, 8'h00}, 1'b0, '0},
        '{'{OP_TOKEN, 32'h0, 8'h00, 16'h0000, 8'h00}, 1'b0, '0},
        // Longest copy from the far end of the window, mostly never written.
        '{'{OP_TOKEN, 32'h0, 8'h00, 16'h0FFF, 8'hFF}, 1'b0, '0},
        '{'{OP_TOKEN, 32'h0, 8'h00, 16'hFFFF, 8'h00}, 1'b0, '0},
        '{'{OP_TOKEN, 32'h0, 8'h00, 16'hF005, 8'h00}, 1'b0, '0},
        '{'{OP_MASK,  32'h5A5A_5A5A, 8'h00, 16'h0000, 8'h00}, 1'b0, '0},
        '{'{OP_TOKEN, 32'h0, 8'h11, 16'h3001, 8'h00}, 1'b0, '0},
        '{'{OP_TOKEN, 32'h0, 8'h22, 16'h3001, 8'h00}, 1'b0, '0},
        '{'{OP_TOKEN, 32'h0, 8'h33, 16'h0003, 8'h05}, 1'b0, '0},
        '{'{OP_TOKEN, 32'h0, 8'h44, 16'h7010, 8'h00}, 1'b0, '0},
        '{'{OP_TOKEN, 32'h0, 8'h55, 16'h0000, 8'h00}, 1'b0, '0},
        '{'{OP_TOKEN, 32'h0, 8'h66, 16'h8007, 8'h00}, 1'b0, '0},
        '{'{OP_TOKEN, 32'h0, 8'h77, 16'h0000, 8'h00}, 1'b0, '0},
        '{'{OP_TOKEN, 32'h0, 8'h88, 16'h1000, 8'h00}, 1'b0, '0}
    };

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        gap_odds   = 4;
        stall_odds = 4;
        write_size(PRODUCED_MAX);
        foreach (directed_rows[i])
            send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
        drain();

        // Size just ahead of the output so far, so finished rises mid-phase.
        gap_odds   = 3;
        stall_odds = 3;
        write_size(produced + SIZE_W'($urandom_range(20, 200)));
        run_phase(25);
        drain();

        gap_odds   = 0;
        stall_odds = 2;
        write_size('0);
        run_phase(25);
        drain();

        gap_odds   = 2;
        stall_odds = 0;
        write_size(SIZE_W'($urandom));
        run_phase(25);
        drain();

        gap_odds   = 0;
        stall_odds = 0;
        write_size(PRODUCED_MAX);
        run_phase(25);
        drain();

        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
src/yay0lz_pkg.sv
src/yay0lz_hist_ram.sv
src/yay0lz_seq.sv
src/yay0lz_pack.sv
src/yay0_lz_decompressor.sv
dv/tb.sv
